FILE: sv/shsps_pkg.sv
// -----------------------------------------------------------------------------
// shsps_pkg - shared constants and helpers for the half-step position sequencer
// Holds the position width, the configuration register indexes and the
// eight-entry coil phase table.
// -----------------------------------------------------------------------------
package shsps_pkg;

	// position and target counters, in half-step units
	localparam int PosWidth = 32;
	// width of the reported position and target fields
	localparam int OutPosWidth = 32;
	// signed move distance field
	localparam int MoveWidth = 24;
	// configuration port
	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth = 8;
	localparam int WindowWidth = 8;

	typedef logic [PosWidth-1:0] pos_t;
	typedef logic [2:0] phase_idx_t;
	typedef logic [3:0] coil_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_RUN_ENABLE = 2'd0,
		CFG_HALF_STEP  = 2'd1,
		CFG_REVERSE    = 2'd2,
		CFG_WINDOW     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_MOVE = 1'b1
	} func_t;

	// half-step coil pattern for each phase index
	function automatic coil_t phase_pattern(input phase_idx_t idx);
		coil_t pat;
		unique case (idx)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

	// reverse the bit order of a coil pattern
	function automatic coil_t mirror4(input coil_t v);
		return {v[0], v[1], v[2], v[3]};
	endfunction

endpackage

FILE: sv/stepper_half_step_position_sequencer_top.sv
// -----------------------------------------------------------------------------
// stepper_half_step_position_sequencer_top - four-coil half-step sequencer
// Keeps position and target counters and drives the coils one step per tick
// request until the position lies within the target window.
// -----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_valid/in_ready with func and move_half_steps.
//   A move request (func = 1) adds the signed distance to the target. A tick
//   request (func = 0) takes one step in the configured direction while
//   run_enable is set and the position is outside target +/- window.
//   Every request returns one result on out_valid/out_ready with the coil
//   levels, busy flag, position and target after the update.
//   The result is registered at the edge that accepts the request. Throughput
//   is one request per cycle while the receiver keeps taking results; the single update step
//   (one counter add and one window compare) sets that figure.
//   in_ready stays high while the result register is empty or being taken,
//   so a stalled receiver holds off new requests only while its result waits.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data) taken
//   at any edge with cfg_we high; write it only while the block is idle.
//   Reset clears position, target, phase, busy and coils; run_enable = 0,
//   half_step_mode = 1, reverse = 0, window = 1.
// -----------------------------------------------------------------------------
module stepper_half_step_position_sequencer_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// configuration
	input  logic                                     cfg_we,
	input  logic [shsps_pkg::CfgIndexWidth-1:0]      cfg_index,
	input  logic [shsps_pkg::CfgDataWidth-1:0]       cfg_data,
	// input requests
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     func,
	input  logic signed [shsps_pkg::MoveWidth-1:0]   move_half_steps,
	// results
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [3:0]                               coils,
	output logic                                     busy_res,
	output logic signed [shsps_pkg::OutPosWidth-1:0] position,
	output logic signed [shsps_pkg::OutPosWidth-1:0] target
);
	import shsps_pkg::*;

	// configuration registers
	logic                   run_enable_q;
	logic                   half_step_q;
	logic                   reverse_q;
	logic [WindowWidth-1:0] window_q;

	// sequencer state
	pos_t       position_q;
	pos_t       target_q;
	phase_idx_t phase_q;
	logic       busy_q;
	coil_t      coil_q;

	// next state
	pos_t       position_d;
	pos_t       target_d;
	phase_idx_t phase_d;
	logic       busy_d;
	coil_t      coil_d;

	// result register
	logic                   out_valid_q;
	coil_t                  coils_q;
	logic                   busy_res_q;
	logic [OutPosWidth-1:0] position_res_q;
	logic [OutPosWidth-1:0] target_res_q;

	logic in_fire;
	pos_t move_ext;
	pos_t dist_pos;
	pos_t dist_biased;
	pos_t window_span;
	logic in_window;
	pos_t step_size;
	logic [3:0] phase_sum;
	coil_t pattern;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enable_q <= 1'b0;
			half_step_q  <= 1'b1;
			reverse_q    <= 1'b0;
			window_q     <= WindowWidth'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RUN_ENABLE: run_enable_q <= cfg_data[0];
				CFG_HALF_STEP:  half_step_q  <= cfg_data[0];
				CFG_REVERSE:    reverse_q    <= cfg_data[0];
				CFG_WINDOW:     window_q     <= cfg_data[WindowWidth-1:0];
				default: ;
			endcase
		end
	end

	// window test: |pos - tgt| <= w  <=>  (pos - tgt + w) mod 2^n <= 2w
	assign dist_pos    = position_q - target_q;
	assign window_span = PosWidth'(window_q);
	assign dist_biased = dist_pos + window_span;
	assign in_window   = dist_biased <= (window_span << 1);

	assign move_ext  = PosWidth'(move_half_steps);
	assign step_size = half_step_q ? PosWidth'(1) : PosWidth'(2);
	assign phase_sum = {1'b0, phase_q} + (half_step_q ? 4'd1 : 4'd2);
	assign pattern   = phase_pattern(phase_q);

	// state update for one request
	always_comb begin
		position_d = position_q;
		target_d   = target_q;
		phase_d    = phase_q;
		busy_d     = busy_q;
		coil_d     = coil_q;
		unique case (func_t'(func))
			FUNC_MOVE: begin
				target_d = target_q + move_ext;
			end
			FUNC_TICK: begin
				if (run_enable_q) begin
					if (in_window) begin
						busy_d = 1'b0;
					end else begin
						busy_d     = 1'b1;
						coil_d     = reverse_q ? pattern : mirror4(pattern);
						position_d = reverse_q ? (position_q - step_size)
						                       : (position_q + step_size);
						phase_d    = phase_sum[3] ? 3'd0 : phase_sum[2:0];
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			target_q   <= '0;
			phase_q    <= '0;
			busy_q     <= 1'b0;
			coil_q     <= '0;
		end else if (in_fire) begin
			position_q <= position_d;
			target_q   <= target_d;
			phase_q    <= phase_d;
			busy_q     <= busy_d;
			coil_q     <= coil_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			coils_q        <= coil_d;
			busy_res_q     <= busy_d;
			position_res_q <= OutPosWidth'(position_d);
			target_res_q   <= OutPosWidth'(target_d);
		end
	end

	assign out_valid = out_valid_q;
	assign coils     = coils_q;
	assign busy_res  = busy_res_q;
	assign position  = signed'(position_res_q);
	assign target    = signed'(target_res_q);

endmodule
